// ===== hdl/tksk_pkg.sv =====
// Shared types and constants for the top-k score keeper.
package tksk_pkg;

	localparam int MAX_ENTRIES = 128;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int LIM_W       = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [7:0] TOP_COUNT_RESET = 8'd101;

	localparam logic [1:0] KIND_OFFER = 2'd0;
	localparam logic [1:0] KIND_DRAIN = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] key;
		logic [31:0] score;
		logic [30:0] exclude_key;
	} req_t;

	typedef struct packed {
		logic        valid_res;
		logic [30:0] out_key;
		logic [31:0] out_score;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [30:0] key;
		logic [31:0] score;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [30:0] key;
		logic [31:0] score;
	} cell_ctrl_t;

endpackage

// ===== hdl/top_k_score_keeper.sv =====
// Top level of the top-k score keeper: control, result register and the cell chain.
//
// Keeps up to top_count (key, score) pairs, but never more than MAX_ENTRIES, in
// descending score order in a row of MAX_ENTRIES cells, ties kept in arrival order.
// Offers and clears are accepted while a result waits. A drain that finds the
// best entry carrying exclude_key with another entry behind it first shifts the
// chain up to drop it and then emits the new head, waiting there for as long as
// the result register is full and stalled; every request is held off until that
// head is emitted. A drain is held off while the result register is full and
// stalled, since every drain yields exactly one result.
module top_k_score_keeper (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  tksk_pkg::req_t  req,
	output logic            res_valid,
	input  logic            res_stall,
	output tksk_pkg::res_t  res,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata
);

	localparam int N = tksk_pkg::MAX_ENTRIES;
	localparam int CW = tksk_pkg::CNT_W;
	localparam int LW = tksk_pkg::LIM_W;

	logic [7:0]    top_count_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          pend_q, pend_d;
	logic          res_valid_q;
	tksk_pkg::res_t res_q;

	tksk_pkg::cell_ctrl_t ctrl;
	tksk_pkg::entry_t     entries [N];
	logic [N-1:0]         ge;
	logic [N-1:0]         occ;

	logic          accept;
	logic          out_free;
	logic          emit;
	tksk_pkg::res_t emit_res;
	logic [LW-1:0] tc_w, lim, cnt_w;
	logic          any_lt;
	logic          cnt_one;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			assign occ[g] = cnt_q > CW'(g);
			if (g == 0) begin : g_first
				tksk_cell u_cell (
					.clk        (clk),
					.ctrl       (ctrl),
					.occ        (occ[g]),
					.ge_prev    (1'b1),
					.prev_entry (entries[g]),
					.next_entry (entries[g+1]),
					.entry      (entries[g]),
					.ge         (ge[g])
				);
			end else if (g == N - 1) begin : g_end
				tksk_cell u_cell (
					.clk        (clk),
					.ctrl       (ctrl),
					.occ        (occ[g]),
					.ge_prev    (ge[g-1]),
					.prev_entry (entries[g-1]),
					.next_entry (entries[g]),
					.entry      (entries[g]),
					.ge         (ge[g])
				);
			end else begin : g_mid
				tksk_cell u_cell (
					.clk        (clk),
					.ctrl       (ctrl),
					.occ        (occ[g]),
					.ge_prev    (ge[g-1]),
					.prev_entry (entries[g-1]),
					.next_entry (entries[g+1]),
					.entry      (entries[g]),
					.ge         (ge[g])
				);
			end
		end
	endgenerate

	assign tc_w    = LW'(top_count_q);
	assign lim     = (tc_w > LW'(N)) ? LW'(N) : tc_w;
	assign cnt_w   = LW'(cnt_q);
	assign any_lt  = |(occ & ~ge);
	assign cnt_one = cnt_q == CW'(1);

	assign out_free  = !res_valid_q || !res_stall;
	assign req_stall = pend_q ||
		((req.kind == tksk_pkg::KIND_DRAIN) && res_valid_q && res_stall);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		ctrl.op    = tksk_pkg::CELL_HOLD;
		ctrl.key   = req.key;
		ctrl.score = req.score;
		cnt_d      = cnt_q;
		pend_d     = pend_q;
		emit       = 1'b0;
		emit_res.valid_res = 1'b1;
		emit_res.out_key   = entries[0].key;
		emit_res.out_score = entries[0].score;
		emit_res.last      = cnt_one;
		if (pend_q) begin
			if (out_free) begin
				emit    = 1'b1;
				ctrl.op = tksk_pkg::CELL_REMOVE;
				cnt_d   = cnt_q - CW'(1);
				pend_d  = 1'b0;
			end
		end else if (accept) begin
			unique case (req.kind)
				tksk_pkg::KIND_OFFER: begin
					if ((lim != '0) && ((cnt_w < lim) || any_lt)) begin
						ctrl.op = tksk_pkg::CELL_INSERT;
						if (cnt_w < lim) begin
							cnt_d = cnt_q + CW'(1);
						end
					end
				end
				tksk_pkg::KIND_DRAIN: begin
					if (cnt_q == '0) begin
						emit = 1'b1;
						emit_res = '{valid_res: 1'b0, out_key: '0, out_score: '0, last: 1'b1};
					end else if (entries[0].key == req.exclude_key) begin
						ctrl.op = tksk_pkg::CELL_REMOVE;
						cnt_d   = cnt_q - CW'(1);
						if (cnt_one) begin
							emit = 1'b1;
							emit_res = '{valid_res: 1'b0, out_key: '0, out_score: '0,
								last: 1'b1};
						end else begin
							pend_d = 1'b1;
						end
					end else begin
						emit    = 1'b1;
						ctrl.op = tksk_pkg::CELL_REMOVE;
						cnt_d   = cnt_q - CW'(1);
					end
				end
				tksk_pkg::KIND_CLEAR: cnt_d = '0;
				default: cnt_d = cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= tksk_pkg::TOP_COUNT_RESET;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				top_count_q <= cfg_wdata;
			end
			cnt_q  <= cnt_d;
			pend_q <= pend_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hdl/tksk_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts down on insert, up on removal.
module tksk_cell (
	input  logic                clk,
	input  tksk_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  logic                ge_prev,
	input  tksk_pkg::entry_t    prev_entry,
	input  tksk_pkg::entry_t    next_entry,
	output tksk_pkg::entry_t    entry,
	output logic                ge
);

	tksk_pkg::entry_t entry_q;
	tksk_pkg::entry_t entry_d;

	assign ge    = occ && (entry_q.score >= ctrl.score);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		unique case (ctrl.op)
			tksk_pkg::CELL_INSERT: begin
				if (!ge) begin
					if (ge_prev) begin
						entry_d.key   = ctrl.key;
						entry_d.score = ctrl.score;
					end else begin
						entry_d = prev_entry;
					end
				end
			end
			tksk_pkg::CELL_REMOVE: entry_d = next_entry;
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule
